@@ rtl/display_power_idle_sleep_manager_unit_macros.svh @@
// Assertion macros for the display power manager.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef DISPLAY_POWER_IDLE_SLEEP_MANAGER_UNIT_MACROS_SVH
`define DISPLAY_POWER_IDLE_SLEEP_MANAGER_UNIT_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define DPISM_CHK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while in reset.
`define DPISM_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dpism_pkg.sv @@
// Shared types, codes and constants of the display power manager.
// No dependencies; imported by every module of the block.
package dpism_pkg;

	localparam int CMD_W      = 3;
	localparam int LDR_W      = 12;
	localparam int LVL_W      = 8;
	localparam int MODE_W     = 2;
	localparam int PRESS_W    = 16;
	localparam int IDLE_W     = 24;
	localparam int CNT_W      = 16;
	localparam int DEB_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK,
		CMD_BUTTON,
		CMD_ACTIVITY,
		CMD_SET_LEVEL,
		CMD_TOGGLE,
		CMD_SET_MODE,
		CMD_FORCE_SLEEP,
		CMD_FORCE_WAKE
	} cmd_t;

	typedef enum logic [MODE_W-1:0] {PWR_ACTIVE, PWR_IDLE, PWR_SLEEP} pwr_t;
	typedef enum logic [MODE_W-1:0] {CPU_HIGH, CPU_BALANCED, CPU_LOW} cpu_t;
	typedef enum logic [MODE_W-1:0] {BL_MANUAL, BL_AUTO, BL_OFF} bl_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IDLE_TIMEOUT,
		REG_SLEEP_TIMEOUT,
		REG_AUTO_INTERVAL,
		REG_AUTO_MIN,
		REG_AUTO_MAX,
		REG_DIM_LEVEL,
		REG_FULL_LEVEL
	} cfg_reg_t;

	typedef struct packed {
		logic [IDLE_W-1:0] idle_timeout;
		logic [IDLE_W-1:0] sleep_timeout;
		logic [CNT_W-1:0]  auto_interval;
		logic [LVL_W-1:0]  auto_min;
		logic [LVL_W-1:0]  auto_max;
		logic [LVL_W-1:0]  dim;
		logic [LVL_W-1:0]  full;
	} cfg_t;

	// One event after the sensor has been scaled to 0..255.
	typedef struct packed {
		cmd_t              cmd;
		logic [LVL_W-1:0]  frac;
		logic [LVL_W-1:0]  req_level;
		logic [MODE_W-1:0] req_mode;
	} item_t;

	typedef struct packed {
		pwr_t               pwr;
		cpu_t               cpu;
		bl_mode_t           bl;
		logic [LVL_W-1:0]   drive;
		logic [LVL_W-1:0]   stored;
		logic [PRESS_W-1:0] press;
		logic [IDLE_W-1:0]  idle;
	} res_t;

	localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST  = 24'd30000;
	localparam logic [IDLE_W-1:0] SLEEP_TIMEOUT_RST = 24'd120000;
	localparam logic [CNT_W-1:0]  AUTO_INTERVAL_RST = 16'd500;
	localparam logic [LVL_W-1:0]  AUTO_MIN_RST      = 8'd10;
	localparam logic [LVL_W-1:0]  AUTO_MAX_RST      = 8'd255;
	localparam logic [LVL_W-1:0]  DIM_LEVEL_RST     = 8'd50;
	localparam logic [LVL_W-1:0]  FULL_LEVEL_RST    = 8'd255;

	localparam logic [DEB_W-1:0]  DEBOUNCE_TICKS = 8'd200;
	localparam logic [CNT_W-1:0]  WAKE_TICKS     = 16'd60000;
	localparam logic [IDLE_W-1:0] IDLE_MAX       = 24'hFF_FFFF;
	localparam logic [CNT_W-1:0]  AUTO_CNT_MAX   = 16'hFFFF;

	// Sensor clamp window and the scale 255/3000 = 17/200 = 17/8/25.
	localparam logic [LDR_W-1:0] LDR_LOW     = 12'd500;
	localparam logic [LDR_W-1:0] LDR_HIGH    = 12'd3500;
	localparam logic [LDR_W-1:0] LDR_SPAN    = 12'd3000;
	localparam logic [4:0]       SCALE_MUL   = 5'd17;
	localparam logic [12:0]      RECIP_25    = 13'd5243;
	localparam int               RECIP_SHIFT = 17;

endpackage

@@ rtl/dpism_cfg_regs.sv @@
// Configuration register file of the display power manager.
// Depends on dpism_pkg for the register codes and the cfg_t layout.
module dpism_cfg_regs import dpism_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_timeout  <= IDLE_TIMEOUT_RST;
			cfg_q.sleep_timeout <= SLEEP_TIMEOUT_RST;
			cfg_q.auto_interval <= AUTO_INTERVAL_RST;
			cfg_q.auto_min      <= AUTO_MIN_RST;
			cfg_q.auto_max      <= AUTO_MAX_RST;
			cfg_q.dim           <= DIM_LEVEL_RST;
			cfg_q.full          <= FULL_LEVEL_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_IDLE_TIMEOUT:  cfg_q.idle_timeout  <= wr_data[IDLE_W-1:0];
				REG_SLEEP_TIMEOUT: cfg_q.sleep_timeout <= wr_data[IDLE_W-1:0];
				REG_AUTO_INTERVAL: cfg_q.auto_interval <= wr_data[CNT_W-1:0];
				REG_AUTO_MIN:      cfg_q.auto_min      <= wr_data[LVL_W-1:0];
				REG_AUTO_MAX:      cfg_q.auto_max      <= wr_data[LVL_W-1:0];
				REG_DIM_LEVEL:     cfg_q.dim           <= wr_data[LVL_W-1:0];
				REG_FULL_LEVEL:    cfg_q.full          <= wr_data[LVL_W-1:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/dpism_ldr_scale.sv @@
// Light sensor front end: clamp to 500..3500 and scale onto 0..255.
// Depends on dpism_pkg for the clamp window and reciprocal constants.
module dpism_ldr_scale import dpism_pkg::*; (
	input  logic [LDR_W-1:0] sample,
	output logic [LVL_W-1:0] frac
);

	logic [LDR_W-1:0] offs;
	logic [15:0]      by17;
	logic [25:0]      recip;

	always_comb begin
		if (sample < LDR_LOW) begin
			offs = '0;
		end else if (sample > LDR_HIGH) begin
			offs = LDR_SPAN;
		end else begin
			offs = sample - LDR_LOW;
		end
	end

	// offs*255/3000 == ((offs*17) >> 3) / 25; the reciprocal is exact below 43690
	assign by17  = {4'b0, offs} * {11'b0, SCALE_MUL};
	assign recip = {13'b0, by17[15:3]} * {13'b0, RECIP_25};
	assign frac  = recip[RECIP_SHIFT +: LVL_W];

endmodule

@@ rtl/dpism_core.sv @@
// Power, CPU and backlight state update for one event per cycle while load is high.
// Depends on dpism_pkg; the state registers double as the result register.
module dpism_core import dpism_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	typedef struct packed {
		res_t             r;
		logic [DEB_W-1:0] deb;
		logic [CNT_W-1:0] auto_cnt;
		logic [CNT_W-1:0] wake;
	} st_t;

	st_t st_q;
	st_t nxt;

	logic               desc;
	logic [LVL_W-1:0]   mag;
	logic [2*LVL_W-1:0] prod;
	logic [2*LVL_W-1:0] rnd;
	logic [LVL_W-1:0]   qa;
	logic [LVL_W-1:0]   auto_lvl;
	logic [LVL_W:0]     dim_sum;
	logic [LVL_W-1:0]   dim_avg;

	// Auto level: min + frac*(max-min)/255, truncated toward zero either way.
	assign desc     = cfg.auto_max < cfg.auto_min;
	assign mag      = desc ? (cfg.auto_min - cfg.auto_max) : (cfg.auto_max - cfg.auto_min);
	assign prod     = {{LVL_W{1'b0}}, item.frac} * {{LVL_W{1'b0}}, mag};
	// exact divide by 255 for products of two 8-bit values
	assign rnd      = prod + {{LVL_W{1'b0}}, prod[2*LVL_W-1:LVL_W]} + 16'd1;
	assign qa       = rnd[2*LVL_W-1:LVL_W];
	assign auto_lvl = desc ? (cfg.auto_min - qa) : (cfg.auto_min + qa);
	assign dim_sum  = {1'b0, cfg.auto_min} + {1'b0, cfg.dim};
	assign dim_avg  = dim_sum[LVL_W:1];

	function automatic st_t f_set_level(st_t s, logic [LVL_W-1:0] lvl);
		st_t r;
		r = s;
		if (!(r.r.bl == BL_OFF && lvl != '0)) begin
			r.r.stored = lvl;
			r.r.drive  = lvl;
		end
		return r;
	endfunction

	function automatic st_t f_auto(st_t s, logic [LVL_W-1:0] al);
		st_t r;
		r = s;
		r.r.stored = al;
		r.r.drive  = al;
		return r;
	endfunction

	function automatic st_t f_set_mode(st_t s, bl_mode_t m, logic [LVL_W-1:0] al,
			logic [LVL_W-1:0] full);
		st_t r;
		r = s;
		r.r.bl = m;
		case (m)
			BL_MANUAL: r = f_set_level(r, (r.r.stored != '0) ? r.r.stored : full);
			BL_AUTO:   r = f_auto(r, al);
			default:   r.r.drive = '0;
		endcase
		return r;
	endfunction

	function automatic st_t f_enter_sleep(st_t s);
		st_t r;
		r = s;
		r.r.pwr   = PWR_SLEEP;
		r.r.drive = '0;
		r.r.cpu   = CPU_LOW;
		r.wake    = '0;
		return r;
	endfunction

	function automatic st_t f_exit_sleep(st_t s, logic [LVL_W-1:0] al,
			logic [LVL_W-1:0] full);
		st_t r;
		r = s;
		r.r.pwr  = PWR_ACTIVE;
		r.r.idle = '0;
		r.wake   = '0;
		r.r.cpu  = CPU_HIGH;
		if (r.r.bl == BL_AUTO) begin
			r = f_auto(r, al);
		end else begin
			r.r.bl     = BL_MANUAL;
			r.r.stored = full;
			r.r.drive  = full;
		end
		return r;
	endfunction

	function automatic st_t f_return_active(st_t s, logic [LVL_W-1:0] al,
			logic [LVL_W-1:0] full);
		st_t r;
		r = s;
		r.r.pwr = PWR_ACTIVE;
		r.r.cpu = CPU_HIGH;
		if (r.r.bl == BL_MANUAL) begin
			r = f_set_level(r, full);
		end else if (r.r.bl == BL_AUTO) begin
			r = f_auto(r, al);
		end
		return r;
	endfunction

	function automatic st_t f_activity(st_t s, logic [LVL_W-1:0] al,
			logic [LVL_W-1:0] full);
		st_t r;
		r = s;
		r.r.idle = '0;
		if (r.r.pwr == PWR_IDLE) begin
			r = f_return_active(r, al, full);
		end
		return r;
	endfunction

	always_comb begin
		nxt = st_q;
		unique case (item.cmd)
			CMD_TICK: begin
				if (nxt.r.idle != IDLE_MAX) nxt.r.idle = nxt.r.idle + 24'd1;
				if (nxt.deb < DEBOUNCE_TICKS) nxt.deb = nxt.deb + 8'd1;
				if (nxt.r.pwr == PWR_SLEEP) begin
					// auto counter freezes while asleep
					nxt.wake = nxt.wake + 16'd1;
					if (nxt.wake >= WAKE_TICKS) nxt = f_exit_sleep(nxt, auto_lvl, cfg.full);
				end else begin
					if (nxt.r.bl == BL_AUTO) begin
						if (nxt.auto_cnt != AUTO_CNT_MAX) nxt.auto_cnt = nxt.auto_cnt + 16'd1;
						if (nxt.auto_cnt >= cfg.auto_interval) begin
							nxt.auto_cnt = '0;
							nxt          = f_auto(nxt, auto_lvl);
						end
					end
					if (nxt.r.idle >= cfg.sleep_timeout) begin
						nxt = f_enter_sleep(nxt);
					end else if (nxt.r.idle >= cfg.idle_timeout) begin
						if (nxt.r.pwr == PWR_ACTIVE) begin
							nxt.r.pwr = PWR_IDLE;
							nxt.r.cpu = CPU_BALANCED;
							if (nxt.r.bl == BL_MANUAL) begin
								nxt.r.drive  = cfg.dim;
								nxt.r.stored = cfg.dim;
							end else if (nxt.r.bl == BL_AUTO) begin
								nxt.r.drive  = dim_avg;
								nxt.r.stored = dim_avg;
							end
						end
					end else if (nxt.r.pwr == PWR_IDLE) begin
						nxt = f_return_active(nxt, auto_lvl, cfg.full);
					end
				end
			end
			CMD_BUTTON: begin
				if (nxt.deb >= DEBOUNCE_TICKS) begin
					nxt.deb     = '0;
					nxt.r.press = nxt.r.press + 16'd1;
					if (nxt.r.pwr == PWR_SLEEP) begin
						nxt = f_exit_sleep(nxt, auto_lvl, cfg.full);
					end else begin
						// cycle manual -> auto -> off -> manual at full level
						case (nxt.r.bl)
							BL_MANUAL: nxt = f_set_mode(nxt, BL_AUTO, auto_lvl, cfg.full);
							BL_AUTO:   nxt = f_set_mode(nxt, BL_OFF, auto_lvl, cfg.full);
							default: begin
								nxt.r.stored = cfg.full;
								nxt          = f_set_mode(nxt, BL_MANUAL, auto_lvl, cfg.full);
							end
						endcase
					end
					nxt = f_activity(nxt, auto_lvl, cfg.full);
				end
			end
			CMD_ACTIVITY: nxt = f_activity(nxt, auto_lvl, cfg.full);
			CMD_SET_LEVEL: nxt = f_set_level(nxt, item.req_level);
			CMD_TOGGLE: begin
				nxt = f_set_level(nxt, (nxt.r.stored != '0) ? {LVL_W{1'b0}} : cfg.full);
			end
			CMD_SET_MODE: begin
				if (item.req_mode <= MODE_W'(BL_OFF)) begin
					nxt = f_set_mode(nxt, bl_mode_t'(item.req_mode), auto_lvl, cfg.full);
				end
			end
			CMD_FORCE_SLEEP: nxt = f_enter_sleep(nxt);
			CMD_FORCE_WAKE: begin
				if (nxt.r.pwr == PWR_SLEEP) nxt = f_exit_sleep(nxt, auto_lvl, cfg.full);
			end
			default: begin
				// all codes are decoded above
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.r.pwr    <= PWR_ACTIVE;
			st_q.r.cpu    <= CPU_HIGH;
			st_q.r.bl     <= BL_MANUAL;
			st_q.r.drive  <= FULL_LEVEL_RST;
			st_q.r.stored <= FULL_LEVEL_RST;
			st_q.r.press  <= '0;
			st_q.r.idle   <= '0;
			st_q.deb      <= '0;
			st_q.auto_cnt <= '0;
			st_q.wake     <= '0;
		end else if (load) begin
			st_q <= nxt;
		end
	end

	assign res = st_q.r;

endmodule

@@ rtl/display_power_idle_sleep_manager_unit.sv @@
// Display power, idle and sleep manager. Each input beat is one event (millisecond
// tick, debounced button press, user activity, set level, level toggle, set mode,
// force sleep, force wake) together with the current light-sensor sample; each
// accepted beat yields exactly one output beat carrying the power state, CPU speed
// mode, backlight mode, driven and stored backlight levels, press count and idle
// time after that event. The block takes one beat per clock, sustained while m_tready
// is high: the sensor is clamped and scaled into the input register, and the state
// update then completes into the state registers, which also serve as the output
// register. The throughput is set by that one state register loop, with a single
// 8x8 multiply for the auto level in it.
// The input register can take a new beat while it is empty and a result waits on m_tready.
// Configuration writes are taken at any time (cfg_ready is tied high) but should
// only be issued while no beat is in flight. Uses dpism_pkg, dpism_cfg_regs,
// dpism_ldr_scale, dpism_core and the assertion macro header.
`include "display_power_idle_sleep_manager_unit_macros.svh"

module display_power_idle_sleep_manager_unit import dpism_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// event stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // ldr_sample[11:0], req_level[19:12], req_mode[21:20]
	input  logic [CMD_W-1:0]      s_tuser,  // cmd[2:0]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // power_state[1:0], cpu_speed[3:2],
	                                        // light_mode[5:4], drive_level[13:6],
	                                        // stored_level[21:14], press_total[37:22],
	                                        // idle_ms[61:38]
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t             cfg;
	logic [LVL_W-1:0] frac;
	item_t            item_in;
	item_t            item_s1;
	logic             valid_s1;
	logic             m_valid_q;
	logic             out_free;
	logic             load;
	logic             s_accept;
	res_t             res;

	assign cfg_ready = 1'b1;

	dpism_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Scale the sensor on the way in so the state loop sees only an 8-bit fraction.
	dpism_ldr_scale u_ldr (
		.sample (s_tdata[LDR_W-1:0]),
		.frac   (frac)
	);

	assign item_in.cmd       = cmd_t'(s_tuser);
	assign item_in.frac      = frac;
	assign item_in.req_level = s_tdata[LDR_W +: LVL_W];
	assign item_in.req_mode  = s_tdata[LDR_W+LVL_W +: MODE_W];

	// The output slot frees when empty or taken this cycle; the input register then
	// moves into the state update. Accept a new beat whenever the input register
	// is empty or drains in the same cycle.
	assign out_free = !m_valid_q || m_tready;
	assign load     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Hold the item payload until it is consumed.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1 <= item_in;
		end
	end

	dpism_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, res.idle, res.press, res.stored, res.drive,
		res.bl, res.cpu, res.pwr};

	// CPU mode tracks the power state one for one: high, balanced, low.
	`DPISM_CHK_IMP(a_cpu_follows_power, 1'b1, MODE_W'(res.pwr) == MODE_W'(res.cpu), "cpu mode out of step with power state")
	// Backlight off never drives a nonzero level.
	`DPISM_CHK_IMP(a_off_is_dark, res.bl == BL_OFF, res.drive == '0, "backlight off but drive nonzero")
	// A waiting input beat is neither dropped nor altered while the output stalls.
	`DPISM_CHK_NEXT(a_s1_held, valid_s1 && !out_free, valid_s1 && $stable(item_s1), "held input beat lost")
	// State and result change only when a beat moves into the update.
	`DPISM_CHK_NEXT(a_state_on_load, !load, $stable(res), "state changed without a beat")

endmodule

@@ verif/display_power_idle_sleep_manager_unit_test.sv @@
// Self-checking testbench for display_power_idle_sleep_manager_unit: events in, one status beat out.
// Depends on dpism_pkg and the block's RTL; predicts each status beat from its own state copy.
`timescale 1ns / 100ps

module display_power_idle_sleep_manager_unit_test import dpism_pkg::*;;

	localparam int GAP_PCT      = 21;     // chance of an idle cycle on either side, in percent
	localparam int DRAIN_CYCLES = 4;      // input register plus state register, with margin

	// One event as it travels on the slave side.
	typedef struct {
		cmd_t              cmd;
		logic [LDR_W-1:0]  ldr;
		logic [LVL_W-1:0]  lvl;
		logic [MODE_W-1:0] mode;
	} ev_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;  // ldr_sample[11:0], req_level[19:12], req_mode[21:20]
	logic [CMD_W-1:0]      s_tuser   = '0;  // cmd[2:0]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // power_state[1:0], cpu_speed[3:2], light_mode[5:4],
	                                        // drive_level[13:6], stored_level[21:14],
	                                        // press_total[37:22], idle_ms[61:38]
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	display_power_idle_sleep_manager_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Events waiting to be offered, and status beats owed by the block, oldest first.
	ev_t  event_backlog[$];
	res_t status_due[$];

	bit ev_taken    = 1'b0;  // set at the edge that takes a beat, cleared by the feeder
	bit steady_flow = 1'b0;  // suppress idle cycles on both sides

	int mismatches   = 0;
	int events_taken = 0;
	int beats_seen   = 0;
	int reg_writes   = 0;
	int sleeps_begun = 0;
	int sleeps_ended = 0;
	int presses_ok   = 0;

	// ------------------------------------------------------------------
	// Predicted state of the manager and its register file
	// ------------------------------------------------------------------
	logic [IDLE_W-1:0] cfg_idle_to, cfg_sleep_to;
	logic [CNT_W-1:0]  cfg_interval;
	logic [LVL_W-1:0]  cfg_amin, cfg_amax, cfg_dim, cfg_full;

	pwr_t               st_pwr;
	cpu_t               st_cpu;
	bl_mode_t           st_bl;
	logic [LVL_W-1:0]   st_level, st_drive;
	logic [IDLE_W-1:0]  st_idle;
	logic [DEB_W-1:0]   st_debounce;
	logic [CNT_W-1:0]   st_auto, st_wake;
	logic [PRESS_W-1:0] st_press;

	function automatic void power_reset();
		cfg_idle_to  = IDLE_TIMEOUT_RST;
		cfg_sleep_to = SLEEP_TIMEOUT_RST;
		cfg_interval = AUTO_INTERVAL_RST;
		cfg_amin     = AUTO_MIN_RST;
		cfg_amax     = AUTO_MAX_RST;
		cfg_dim      = DIM_LEVEL_RST;
		cfg_full     = FULL_LEVEL_RST;
		st_pwr       = PWR_ACTIVE;
		st_cpu       = CPU_HIGH;
		st_bl        = BL_MANUAL;
		st_level     = FULL_LEVEL_RST;
		st_drive     = FULL_LEVEL_RST;
		st_idle      = '0;
		st_debounce  = '0;
		st_auto      = '0;
		st_wake      = '0;
		st_press     = '0;
	endfunction

	function automatic void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_IDLE_TIMEOUT:  cfg_idle_to  = val[IDLE_W-1:0];
			REG_SLEEP_TIMEOUT: cfg_sleep_to = val[IDLE_W-1:0];
			REG_AUTO_INTERVAL: cfg_interval = val[CNT_W-1:0];
			REG_AUTO_MIN:      cfg_amin     = val[LVL_W-1:0];
			REG_AUTO_MAX:      cfg_amax     = val[LVL_W-1:0];
			REG_DIM_LEVEL:     cfg_dim      = val[LVL_W-1:0];
			REG_FULL_LEVEL:    cfg_full     = val[LVL_W-1:0];
			default: ;
		endcase
	endfunction

	// Clamp the sensor to its window, scale to 0..255, then stretch onto min..max.
	// An inverted range runs downward; both directions truncate toward zero.
	function automatic logic [LVL_W-1:0] sensor_level(logic [LDR_W-1:0] ldr);
		int c, n, diff, q;
		c = int'(ldr);
		if (c < int'(LDR_LOW)) c = int'(LDR_LOW);
		if (c > int'(LDR_HIGH)) c = int'(LDR_HIGH);
		n = ((c - int'(LDR_LOW)) * 255) / int'(LDR_SPAN);
		diff = int'(cfg_amax) - int'(cfg_amin);
		if (diff >= 0) q = (n * diff) / 255;
		else q = -((n * (-diff)) / 255);
		return 8'(int'(cfg_amin) + q);
	endfunction

	function automatic void auto_apply(logic [LDR_W-1:0] ldr);
		st_level = sensor_level(ldr);
		st_drive = st_level;
	endfunction

	// A nonzero level is refused while the backlight is off.
	function automatic void apply_level(logic [LVL_W-1:0] lvl);
		if (st_bl == BL_OFF && lvl != 0) return;
		st_level = lvl;
		st_drive = lvl;
	endfunction

	function automatic void apply_mode(bl_mode_t mode, logic [LDR_W-1:0] ldr);
		st_bl = mode;
		if (mode == BL_MANUAL) apply_level(st_level != 0 ? st_level : cfg_full);
		else if (mode == BL_AUTO) auto_apply(ldr);
		else st_drive = '0;
	endfunction

	function automatic void go_sleep();
		st_pwr   = PWR_SLEEP;
		st_drive = '0;
		st_cpu   = CPU_LOW;
		st_wake  = '0;
		sleeps_begun++;
	endfunction

	function automatic void wake_up(logic [LDR_W-1:0] ldr);
		st_pwr  = PWR_ACTIVE;
		st_idle = '0;
		st_wake = '0;
		st_cpu  = CPU_HIGH;
		sleeps_ended++;
		if (st_bl == BL_AUTO) begin
			auto_apply(ldr);
		end else begin
			st_bl    = BL_MANUAL;
			st_level = cfg_full;
			st_drive = cfg_full;
		end
	endfunction

	function automatic void back_active(logic [LDR_W-1:0] ldr);
		st_pwr = PWR_ACTIVE;
		st_cpu = CPU_HIGH;
		if (st_bl == BL_MANUAL) apply_level(cfg_full);
		else if (st_bl == BL_AUTO) auto_apply(ldr);
	endfunction

	function automatic void note_activity(logic [LDR_W-1:0] ldr);
		st_idle = '0;
		if (st_pwr == PWR_IDLE) back_active(ldr);
	endfunction

	function automatic void on_tick(logic [LDR_W-1:0] ldr);
		logic [LVL_W:0] half_sum;
		if (st_idle < IDLE_MAX) st_idle = st_idle + 1'b1;
		if (st_debounce < DEBOUNCE_TICKS) st_debounce = st_debounce + 1'b1;
		// Asleep: only the wake timer moves, the auto timer stays frozen.
		if (st_pwr == PWR_SLEEP) begin
			st_wake = st_wake + 1'b1;
			if (st_wake >= WAKE_TICKS) wake_up(ldr);
			return;
		end
		if (st_bl == BL_AUTO) begin
			if (st_auto < AUTO_CNT_MAX) st_auto = st_auto + 1'b1;
			if (st_auto >= cfg_interval) begin
				st_auto = '0;
				auto_apply(ldr);
			end
		end
		if (st_idle >= cfg_sleep_to) begin
			go_sleep();
		end else if (st_idle >= cfg_idle_to) begin
			if (st_pwr == PWR_ACTIVE) begin
				st_pwr = PWR_IDLE;
				st_cpu = CPU_BALANCED;
				if (st_bl == BL_MANUAL) begin
					st_drive = cfg_dim;
					st_level = cfg_dim;
				end else if (st_bl == BL_AUTO) begin
					half_sum = ({1'b0, cfg_amin} + {1'b0, cfg_dim}) >> 1;
					st_drive = half_sum[LVL_W-1:0];
					st_level = half_sum[LVL_W-1:0];
				end
			end
		end else if (st_pwr == PWR_IDLE) begin
			back_active(ldr);
		end
	endfunction

	// A press counts only once the debounce window has fully elapsed.
	function automatic void on_button(logic [LDR_W-1:0] ldr);
		bl_mode_t next;
		if (st_debounce < DEBOUNCE_TICKS) return;
		st_debounce = '0;
		st_press    = st_press + 1'b1;
		presses_ok++;
		if (st_pwr == PWR_SLEEP) begin
			wake_up(ldr);
		end else begin
			if (st_bl == BL_MANUAL) begin
				next = BL_AUTO;
			end else if (st_bl == BL_AUTO) begin
				next = BL_OFF;
			end else begin
				next = BL_MANUAL;
				st_level = cfg_full;
			end
			apply_mode(next, ldr);
		end
		note_activity(ldr);
	endfunction

	function automatic res_t power_step(cmd_t cmd, logic [LDR_W-1:0] ldr,
			logic [LVL_W-1:0] lvl, logic [MODE_W-1:0] mode);
		res_t r;
		case (cmd)
			CMD_TICK:        on_tick(ldr);
			CMD_BUTTON:      on_button(ldr);
			CMD_ACTIVITY:    note_activity(ldr);
			CMD_SET_LEVEL:   apply_level(lvl);
			CMD_TOGGLE:      apply_level(st_level != 0 ? '0 : cfg_full);
			CMD_SET_MODE:    if (mode <= BL_OFF) apply_mode(bl_mode_t'(mode), ldr);
			CMD_FORCE_SLEEP: go_sleep();
			CMD_FORCE_WAKE:  if (st_pwr == PWR_SLEEP) wake_up(ldr);
			default: ;
		endcase
		r.pwr    = st_pwr;
		r.cpu    = st_cpu;
		r.bl     = st_bl;
		r.drive  = st_drive;
		r.stored = st_level;
		r.press  = st_press;
		r.idle   = st_idle;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: offer the next event at the falling edge, with random gaps
	// ------------------------------------------------------------------
	always @(negedge clk) begin : feed
		ev_t e;
		if (arst_n && (!s_tvalid || ev_taken)) begin
			ev_taken = 1'b0;
			if (event_backlog.size() != 0 && (steady_flow || $urandom_range(99) >= GAP_PCT)) begin
				e = event_backlog.pop_front();
				s_tuser  <= e.cmd;
				s_tdata  <= {2'b00, e.mode, e.lvl, e.ldr};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Stall the result side at random, never while steady_flow is set.
	always @(negedge clk) begin
		m_tready <= arst_n && (steady_flow || $urandom_range(99) >= GAP_PCT);
	end

	// Advance the predictor on every beat and register write the block takes.
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			apply_reg(cfg_reg_t'(cfg_index), cfg_data);
			reg_writes++;
		end
		if (arst_n && s_tvalid && s_tready) begin
			status_due.push_back(power_step(cmd_t'(s_tuser), s_tdata[11:0], s_tdata[19:12],
				s_tdata[21:20]));
			ev_taken = 1'b1;
			events_taken++;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each status beat with the oldest one owed
	// ------------------------------------------------------------------
	function automatic void check_field(string name, int unsigned want, int unsigned seen);
		if (want != seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : watch
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beats_seen++;
			if (status_due.size() == 0) begin
				$error("status beat with nothing outstanding: %h", m_tdata);
				mismatches++;
			end else begin
				want = status_due.pop_front();
				check_field("power_state",  want.pwr,    m_tdata[1:0]);
				check_field("cpu_speed",    want.cpu,    m_tdata[3:2]);
				check_field("light_mode",   want.bl,     m_tdata[5:4]);
				check_field("drive_level",  want.drive,  m_tdata[13:6]);
				check_field("stored_level", want.stored, m_tdata[21:14]);
				check_field("press_total",  want.press,  m_tdata[37:22]);
				check_field("idle_ms",      want.idle,   m_tdata[61:38]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void post(cmd_t cmd, logic [LDR_W-1:0] ldr = '0,
			logic [LVL_W-1:0] lvl = '0, logic [MODE_W-1:0] mode = '0);
		ev_t e;
		e.cmd  = cmd;
		e.ldr  = ldr;
		e.lvl  = lvl;
		e.mode = mode;
		event_backlog.push_back(e);
	endfunction

	// Favour the clamp edges so both ends of the window are hit often.
	function automatic logic [LDR_W-1:0] pick_ldr();
		case ($urandom_range(9))
			0:       return '0;
			1:       return 12'd499;
			2:       return LDR_LOW;
			3:       return LDR_HIGH;
			4:       return 12'd3501;
			5:       return '1;
			default: return LDR_W'($urandom_range(4095));
		endcase
	endfunction

	function automatic void post_random(cmd_t cmd);
		post(cmd, pick_ldr(), LVL_W'($urandom_range(255)), MODE_W'($urandom_range(3)));
	endfunction

	task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic cfg_all(int unsigned idle_to, int unsigned sleep_to, int unsigned interval,
			int unsigned amin, int unsigned amax, int unsigned dim, int unsigned full);
		cfg_write(REG_IDLE_TIMEOUT,  CFG_DATA_W'(idle_to));
		cfg_write(REG_SLEEP_TIMEOUT, CFG_DATA_W'(sleep_to));
		cfg_write(REG_AUTO_INTERVAL, CFG_DATA_W'(interval));
		cfg_write(REG_AUTO_MIN,      CFG_DATA_W'(amin));
		cfg_write(REG_AUTO_MAX,      CFG_DATA_W'(amax));
		cfg_write(REG_DIM_LEVEL,     CFG_DATA_W'(dim));
		cfg_write(REG_FULL_LEVEL,    CFG_DATA_W'(full));
	endtask

	// Wait until every event is taken and every status beat has come back,
	// then let the pipeline run dry before touching the registers.
	task automatic settle();
		do @(posedge clk);
		while (event_backlog.size() != 0 || s_tvalid || status_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random events, each after a short tick burst; the ticks add up across
	// rounds, so the debounce window clears now and then and a later press lands.
	task automatic random_round(int n_events);
		int burst;
		repeat (n_events) begin
			burst = $urandom_range(6);
			repeat (burst) post(CMD_TICK, pick_ldr());
			if ($urandom_range(99) < 25) post_random(CMD_BUTTON);
			else post_random(cmd_t'($urandom_range(7)));
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence of phases
	// ------------------------------------------------------------------
	initial begin : run
		int idle_to;
		power_reset();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed events under the reset register values.
		post(CMD_TICK, 12'd0);
		post(CMD_BUTTON, 12'd1000);                // still inside the debounce window
		post(CMD_ACTIVITY);
		post(CMD_SET_LEVEL, 12'd0, 8'd0);
		post(CMD_SET_LEVEL, 12'd0, 8'd255);
		post(CMD_TOGGLE);                          // level on: drop to zero
		post(CMD_TOGGLE);                          // level zero: back to full
		post(CMD_SET_MODE, 12'd0, 8'd0, BL_AUTO);  // darkest reading
		post(CMD_SET_MODE, 12'hFFF, 8'd0, BL_AUTO);
		post(CMD_SET_MODE, 12'd2000, 8'd0, BL_AUTO);
		post(CMD_SET_MODE, 12'd2000, 8'd0, 2'd3);  // unused mode code is ignored
		post(CMD_SET_MODE, 12'd0, 8'd0, BL_OFF);
		post(CMD_SET_LEVEL, 12'd0, 8'd7);          // refused while off
		post(CMD_SET_LEVEL, 12'd0, 8'd0);          // zero still taken while off
		post(CMD_TOGGLE);
		post(CMD_SET_MODE, 12'd0, 8'd0, BL_MANUAL);
		post(CMD_FORCE_WAKE);                      // already awake: no effect
		post(CMD_FORCE_SLEEP);
		post(CMD_ACTIVITY);                        // asleep: clears idle time only
		post(CMD_SET_LEVEL, 12'd0, 8'd99);
		post(CMD_FORCE_SLEEP);                     // restart the wake timer
		post(CMD_FORCE_WAKE);
		post(CMD_TICK, 12'd3000);
		settle();

		// Zero timeouts, zero interval and an inverted auto range.
		cfg_all(0, 3, 0, 200, 20, 255, 1);
		post(CMD_SET_MODE, LDR_HIGH, 8'd0, BL_AUTO);
		post(CMD_TICK, 12'd1750);
		post(CMD_ACTIVITY, 12'd600);
		repeat (3) post(CMD_TICK, 12'd2500);
		// Stay asleep until the debounce window has run out, then wake by a press.
		repeat (200) post(CMD_TICK, pick_ldr());
		post(CMD_BUTTON, 12'd2200);
		settle();

		// Random rounds, the first two at the register extremes.
		for (int round = 0; round < 6; round++) begin
			case (round)
				0: cfg_all(1, 1, 1, 0, 0, 0, 1);
				1: cfg_all(IDLE_MAX, IDLE_MAX, AUTO_CNT_MAX, 255, 255, 255, 255);
				default: begin
					idle_to = $urandom_range(40, 1);
					cfg_all(idle_to,
						($urandom_range(3) == 0) ? $urandom_range(30, 1)
						                         : idle_to + $urandom_range(80),
						$urandom_range(12, 1), $urandom_range(255), $urandom_range(255),
						$urandom_range(255), $urandom_range(255, 1));
				end
			endcase
			steady_flow = (round == 2);
			random_round(22);
			settle();
		end
		steady_flow = 1'b0;

		// Drain, bounded so that a lost beat shows up as a leftover.
		do @(posedge clk);
		while (event_backlog.size() != 0 || s_tvalid);
		for (int i = 0; i < 1000 && status_due.size() != 0; i++) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (status_due.size() != 0) begin
			$error("%0d status beats never arrived", status_due.size());
			mismatches += status_due.size();
		end

		$display("%0d events, %0d status beats, %0d register writes, %0d presses accepted",
			events_taken, beats_seen, reg_writes, presses_ok);
		$display("sleep entered %0d times, left %0d times", sleeps_begun, sleeps_ended);
		if (mismatches == 0) begin
			$display("display_power_idle_sleep_manager_unit_test: clean");
		end else begin
			$display("display_power_idle_sleep_manager_unit_test: errors");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("timeout: %0d events taken, %0d beats outstanding", events_taken,
			status_due.size());
		$display("display_power_idle_sleep_manager_unit_test: errors");
		$finish;
	end

endmodule
